/* design/hsl2rgb_pkg.sv */
// Package for the HSL to RGB converter: widths, constants, payload types, rounding divide.
package hsl2rgb_pkg;

	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned THETA_W = FRAC_BITS + 9;
	localparam logic [FRAC_BITS-1:0] ONE = {FRAC_BITS{1'b1}};
	localparam logic [THETA_W-1:0] TURN = THETA_W'(360) << FRAC_BITS;

	localparam int unsigned LUMA_SHIFT = 16;
	localparam logic [LUMA_SHIFT-1:0] LUMA_WT [0:2] = '{16'd13933, 16'd46871, 16'd4732};

	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS-1:0] saturation;
		logic [FRAC_BITS-1:0] lightness;
	} hsl_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] red;
		logic [FRAC_BITS-1:0] green;
		logic [FRAC_BITS-1:0] blue;
	} rgb_t;

	// round(p / ONE), ties up, for p <= ONE * ONE
	function automatic logic [FRAC_BITS-1:0] div_one_round(input logic [2*FRAC_BITS-1:0] p);
		logic [2*FRAC_BITS:0] xh;
		logic [2*FRAC_BITS:0] est;
		logic [2*FRAC_BITS:0] rem;
		logic [FRAC_BITS:0] q;
		xh = (2*FRAC_BITS+1)'(p) + (2*FRAC_BITS+1)'((ONE - 1'b1) >> 1);
		est = xh + (xh >> FRAC_BITS);
		q = est[FRAC_BITS +: FRAC_BITS+1];
		rem = xh - (((2*FRAC_BITS+1)'(q) << FRAC_BITS) - (2*FRAC_BITS+1)'(q));
		if (rem >= (2*FRAC_BITS+1)'(ONE)) begin
			q = q + 1'b1;
		end
		return q[FRAC_BITS-1:0];
	endfunction

endpackage

/* design/hsl2rgb_hue_weight.sv */
// Per-channel hue weight pipeline: angular distance, ramp, rounded divide by the ramp span.
module hsl2rgb_hue_weight #(
	parameter int unsigned CHAN_DEG = 0
) (
	input  logic                                 clk,
	input  logic [hsl2rgb_pkg::THETA_W-1:0]      theta,
	output logic [hsl2rgb_pkg::FRAC_BITS-1:0]    weight
);

	localparam int unsigned F = hsl2rgb_pkg::FRAC_BITS;
	localparam int unsigned TW = hsl2rgb_pkg::THETA_W;
	localparam logic [TW-1:0] TURN = hsl2rgb_pkg::TURN;
	localparam logic [TW-1:0] HALF_TURN = TURN >> 1;
	localparam logic [TW-1:0] CHAN = TW'(CHAN_DEG) << F;
	localparam logic [TW-1:0] WRAP = TURN - CHAN;
	localparam logic [TW-1:0] LIM = TW'(120) << F;
	localparam logic [TW-1:0] SPAN = TW'(60) << F;
	localparam int unsigned NUM_W = F + 6;
	localparam int unsigned PW = 2 * F + 8;
	localparam int unsigned XW = F + 5;
	// twice the span is 15 * 2^(F+3): shift, then divide by 15 via reciprocal
	localparam int unsigned DIV_ODD = 15;
	localparam int unsigned DIV_S = XW + 4;
	localparam int unsigned MW = DIV_S - 3;
	localparam logic [MW-1:0] RECIP = MW'((2 ** DIV_S) / DIV_ODD);
	localparam int unsigned QW = XW - 3;

	logic [TW-1:0] dist_raw;
	logic [TW-1:0] ang_dist;
	logic [TW-1:0] num_full;
	logic          zero_c;
	logic          full_c;
	logic [PW-1:0] ramp_prod;
	logic [XW+MW-1:0] recip_prod;
	logic [XW-1:0] rem;
	logic [QW-1:0] quo;

	logic [NUM_W-1:0] num_s2;
	logic             zero_s2, full_s2;
	logic [XW-1:0]    x_s3;
	logic             zero_s3, full_s3;
	logic [XW-1:0]    x_s4;
	logic [QW-1:0]    q_s4;
	logic             zero_s4, full_s4;

	always_comb begin
		dist_raw = (theta >= CHAN) ? (theta - CHAN) : (theta + WRAP);
		ang_dist = (dist_raw > HALF_TURN) ? (TURN - dist_raw) : dist_raw;
		zero_c = (ang_dist >= LIM);
		num_full = LIM - ang_dist;
		full_c = !zero_c && (num_full >= SPAN);
	end

	assign ramp_prod = PW'(num_s2) * PW'({hsl2rgb_pkg::ONE, 1'b0}) + PW'(SPAN);
	assign recip_prod = (XW+MW)'(x_s3) * (XW+MW)'(RECIP);
	assign rem = x_s4 - ((XW'(q_s4) << 4) - XW'(q_s4));
	assign quo = (rem >= XW'(DIV_ODD)) ? (q_s4 + 1'b1) : q_s4;

	always_ff @(posedge clk) begin
		num_s2 <= num_full[NUM_W-1:0];
		zero_s2 <= zero_c;
		full_s2 <= full_c;

		x_s3 <= ramp_prod[F+3 +: XW];
		zero_s3 <= zero_s2;
		full_s3 <= full_s2;

		x_s4 <= x_s3;
		q_s4 <= recip_prod[DIV_S +: QW];
		zero_s4 <= zero_s3;
		full_s4 <= full_s3;

		if (full_s4) begin
			weight <= hsl2rgb_pkg::ONE;
		end else if (zero_s4) begin
			weight <= '0;
		end else begin
			weight <= quo[F-1:0];
		end
	end

endmodule

/* design/hsl_to_rgb_converter.sv */
// Each result strobes on done for one cycle, once its start transfer has passed every stage.
// Throughput: one item per clock; fixed 12-stage pipeline, busy is always low.
// The ramp divide (reciprocal multiply plus correction) and the two luma/saturation
// multiply-then-divide steps set the stage count.
// Reset (arst_n low, asynchronous) clears the valid pipeline; items in flight are dropped.
module hsl_to_rgb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hsl2rgb_pkg::hsl_t  hsl,
	output logic               done,
	output hsl2rgb_pkg::rgb_t  rgb
);

	localparam int unsigned F = hsl2rgb_pkg::FRAC_BITS;
	localparam int unsigned TW = hsl2rgb_pkg::THETA_W;
	localparam logic [F-1:0] ONE = hsl2rgb_pkg::ONE;
	localparam int unsigned LW = F + hsl2rgb_pkg::LUMA_SHIFT;
	localparam int unsigned SW = LW + 2;
	localparam int unsigned LAT = 12;

	typedef struct packed {
		logic [F-1:0] sat;
		logic [F-1:0] lm;
		logic [F-1:0] ladd;
	} side_t;

	logic          accept;
	logic [F:0]    l2;
	logic          l_hi;
	side_t         side_in;
	logic [SW-1:0] luma_sum;

	logic [LAT:1]  vld_q;

	logic [TW-1:0] theta_s1;
	side_t         side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [F-1:0]  w_s5 [3];
	logic [2*F-1:0] lp_s6 [3];
	logic [F-1:0]  ladd_s6;
	logic [F-1:0]  sat_s6, sat_s7, sat_s8, sat_s9;
	logic [F-1:0]  c_s7 [3];
	logic [F-1:0]  c_s8 [3];
	logic [F-1:0]  c_s9 [3];
	logic [LW-1:0] lp_s8 [3];
	logic [F-1:0]  y_s9;
	logic [2*F-1:0] py_s10;
	logic [2*F-1:0] pc_s10 [3];
	logic [2*F-1:0] mix_s11 [3];
	logic [F-1:0]  out_s12 [3];

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign done = vld_q[LAT];
	assign rgb = '{red: out_s12[0], green: out_s12[1], blue: out_s12[2]};

	always_comb begin
		l2 = {hsl.lightness, 1'b0};
		l_hi = (l2 > (F+1)'(ONE));
		side_in.sat = hsl.saturation;
		side_in.lm = l_hi ? F'({ONE, 1'b0} - l2) : F'(l2);
		side_in.ladd = l_hi ? F'(l2 - (F+1)'(ONE)) : '0;
		luma_sum = SW'(lp_s8[0]) + SW'(lp_s8[1]) + SW'(lp_s8[2])
			+ SW'(1 << (hsl2rgb_pkg::LUMA_SHIFT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		theta_s1 <= TW'(hsl.hue) * TW'(360);
		side_s1 <= side_in;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;

		ladd_s6 <= side_s5.ladd;
		sat_s6 <= side_s5.sat;
		sat_s7 <= sat_s6;
		sat_s8 <= sat_s7;
		sat_s9 <= sat_s8;
		y_s9 <= luma_sum[hsl2rgb_pkg::LUMA_SHIFT +: F];
		py_s10 <= (2*F)'(y_s9) * (2*F)'(ONE - sat_s9);

		for (int i = 0; i < 3; i++) begin
			lp_s6[i] <= (2*F)'(w_s5[i]) * (2*F)'(side_s5.lm);
			c_s7[i] <= F'((F+1)'(hsl2rgb_pkg::div_one_round(lp_s6[i])) + (F+1)'(ladd_s6));
			c_s8[i] <= c_s7[i];
			lp_s8[i] <= LW'(c_s7[i]) * LW'(hsl2rgb_pkg::LUMA_WT[i]);
			c_s9[i] <= c_s8[i];
			pc_s10[i] <= (2*F)'(c_s9[i]) * (2*F)'(sat_s9);
			mix_s11[i] <= py_s10 + pc_s10[i];
			out_s12[i] <= hsl2rgb_pkg::div_one_round(mix_s11[i]);
		end
	end

	hsl2rgb_hue_weight #(.CHAN_DEG(0)) u_wt_red (
		.clk    (clk),
		.theta  (theta_s1),
		.weight (w_s5[0])
	);

	hsl2rgb_hue_weight #(.CHAN_DEG(240)) u_wt_green (
		.clk    (clk),
		.theta  (theta_s1),
		.weight (w_s5[1])
	);

	hsl2rgb_hue_weight #(.CHAN_DEG(120)) u_wt_blue (
		.clk    (clk),
		.theta  (theta_s1),
		.weight (w_s5[2])
	);

`ifndef NO_ASSERTIONS
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without a matching start transfer");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(hsl.saturation, LAT) == '0)) |->
			((rgb.red == rgb.green) && (rgb.green == rgb.blue)))
		else $error("zero saturation must give equal channels");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(hsl.lightness, LAT) == '0)) |-> (rgb == '0))
		else $error("zero lightness must give black");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(hsl.lightness, LAT) == ONE)) |->
			((rgb.red == ONE) && (rgb.green == ONE) && (rgb.blue == ONE)))
		else $error("full lightness must give white");
`endif

endmodule

/* test/hsl_to_rgb_converter_tb.sv */
// Testbench for hsl_to_rgb_converter: directed and random HSL pixels checked against a predictor.
module hsl_to_rgb_converter_tb;

	localparam int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] ONE = hsl2rgb_pkg::ONE;
	localparam int unsigned N_RANDOM = 450;
	localparam longint unsigned UNIT = 64'(ONE);
	localparam longint unsigned FULL_TURN = 64'd360 << FRAC_BITS;
	localparam longint unsigned RAMP_LIM = 64'd120 << FRAC_BITS;
	localparam longint unsigned RAMP_SPAN = 64'd60 << FRAC_BITS;
	localparam longint unsigned ANG_RED = 0;
	localparam longint unsigned ANG_GREEN = 240;
	localparam longint unsigned ANG_BLUE = 120;
	localparam longint unsigned Y_RED = 13933;
	localparam longint unsigned Y_GREEN = 46871;
	localparam longint unsigned Y_BLUE = 4732;

	class rgb_scoreboard;
		hsl2rgb_pkg::rgb_t expected_q[$];
		int unsigned errors;

		function longint unsigned div_nearest(longint unsigned num, longint unsigned den);
			return (num * 2 + den) / (den * 2);
		endfunction

		function longint unsigned hue_ramp(longint unsigned theta, longint unsigned ang);
			longint unsigned cang;
			longint unsigned ang_dist;
			cang = ang << FRAC_BITS;
			ang_dist = (theta >= cang) ? theta - cang : theta + FULL_TURN - cang;
			if (ang_dist > FULL_TURN / 2)
				ang_dist = FULL_TURN - ang_dist;
			if (ang_dist >= RAMP_LIM)
				return 0;
			if (RAMP_LIM - ang_dist >= RAMP_SPAN)
				return UNIT;
			return div_nearest((RAMP_LIM - ang_dist) * UNIT, RAMP_SPAN);
		endfunction

		function longint unsigned shade(longint unsigned c, longint unsigned l2);
			if (l2 > UNIT)
				return div_nearest(c * (2 * UNIT - l2) + UNIT * (l2 - UNIT), UNIT);
			return div_nearest(c * l2, UNIT);
		endfunction

		function hsl2rgb_pkg::rgb_t hsl_to_rgb(hsl2rgb_pkg::hsl_t px);
			longint unsigned theta;
			longint unsigned l2;
			longint unsigned sat;
			longint unsigned luma;
			longint unsigned r, g, b;
			hsl2rgb_pkg::rgb_t res;
			theta = 64'(px.hue) * 360;
			l2 = 64'(px.lightness) * 2;
			sat = 64'(px.saturation);
			r = shade(hue_ramp(theta, ANG_RED), l2);
			g = shade(hue_ramp(theta, ANG_GREEN), l2);
			b = shade(hue_ramp(theta, ANG_BLUE), l2);
			luma = (Y_RED * r + Y_GREEN * g + Y_BLUE * b + 32768) >> 16;
			res.red = FRAC_BITS'(div_nearest(luma * (UNIT - sat) + r * sat, UNIT));
			res.green = FRAC_BITS'(div_nearest(luma * (UNIT - sat) + g * sat, UNIT));
			res.blue = FRAC_BITS'(div_nearest(luma * (UNIT - sat) + b * sat, UNIT));
			return res;
		endfunction

		function void note_pixel(hsl2rgb_pkg::hsl_t px);
			expected_q.push_back(hsl_to_rgb(px));
		endfunction

		function void check_pixel(hsl2rgb_pkg::rgb_t got);
			hsl2rgb_pkg::rgb_t want;
			if (expected_q.size() == 0) begin
				$error("result with none expected: rgb %h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, actual %0d", want.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	hsl2rgb_pkg::hsl_t hsl;
	logic done;
	hsl2rgb_pkg::rgb_t rgb;

	rgb_scoreboard board = new();

	hsl_to_rgb_converter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hsl(hsl),
		.done(done),
		.rgb(rgb)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_pixel(rgb);
	end

	// one transfer; entered and left at a falling edge
	task automatic send_pixel(hsl2rgb_pkg::hsl_t px);
		start <= 1'b1;
		hsl <= px;
		do @(posedge clk); while (busy);
		board.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic idle_gap(int unsigned n);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if ((n / 80) % 3 == 1 || r < 60)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic hsl2rgb_pkg::hsl_t random_pixel();
		hsl2rgb_pkg::hsl_t px;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			px.hue = FRAC_BITS'(($urandom_range(0, 5) * 4096) / 6 + $urandom_range(0, 6) - 3);
		else
			px.hue = FRAC_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < 15)
			px.saturation = r[0] ? ONE : '0;
		else
			px.saturation = FRAC_BITS'($urandom);
		r = $urandom_range(0, 99);
		if (r < 20)
			px.lightness = FRAC_BITS'($urandom_range(2040, 2055));
		else if (r < 30)
			px.lightness = r[0] ? ONE : '0;
		else
			px.lightness = FRAC_BITS'($urandom);
		return px;
	endfunction

	initial begin
		hsl2rgb_pkg::hsl_t dir_px[$];
		int unsigned drain;
		arst_n = 1'b0;
		start = 1'b0;
		hsl = '0;
		dir_px = '{
			{12'd0, 12'd4095, 12'd2048}, {12'd4095, 12'd4095, 12'd2048},
			{12'd683, 12'd4095, 12'd2048}, {12'd1365, 12'd4095, 12'd2048},
			{12'd1366, 12'd4095, 12'd2048}, {12'd2048, 12'd4095, 12'd2048},
			{12'd2730, 12'd4095, 12'd2048}, {12'd2731, 12'd4095, 12'd2048},
			{12'd3413, 12'd4095, 12'd2048}, {12'd341, 12'd4095, 12'd2048},
			{12'd1000, 12'd0, 12'd2048}, {12'd1000, 12'd4095, 12'd0},
			{12'd1000, 12'd4095, 12'd4095}, {12'd2000, 12'd4095, 12'd2047},
			{12'd3000, 12'd2048, 12'd2048}, {12'd4095, 12'd4095, 12'd4095},
			{12'd0, 12'd0, 12'd0}, {12'hAAA, 12'h555, 12'hAAA},
			{12'h555, 12'hAAA, 12'h555}, {12'd3072, 12'd1, 12'd1},
			{12'd1024, 12'd4094, 12'd4094}
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_px[i]) begin
			idle_gap(i);
			send_pixel(dir_px[i]);
		end
		for (int unsigned n = 0; n < N_RANDOM; n++) begin
			idle_gap(n);
			send_pixel(random_pixel());
		end
		start <= 1'b0;
		drain = 0;
		while (board.expected_q.size() != 0 && drain < 1000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
design/hsl2rgb_pkg.sv
design/hsl2rgb_hue_weight.sv
design/hsl_to_rgb_converter.sv
test/hsl_to_rgb_converter_tb.sv
